FILE: src/strenc_pkg.sv
package strenc_pkg;

    // How one input byte expands on the output.
    typedef enum logic [1:0] {
        K_PLAIN,    // one byte, passed as is (also the end-of-string zero)
        K_ESC,      // backslash and one character
        K_HEX       // backslash, 'x' and two hex digits
    } t_kind;

    // One classified request as it waits in the queue.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
    } t_entry;

    // Queue status seen by the back end.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    localparam logic [7:0] C_NUL      = 8'h00;
    localparam logic [7:0] C_TAB      = 8'h09;
    localparam logic [7:0] C_NL       = 8'h0A;
    localparam logic [7:0] C_CR       = 8'h0D;
    localparam logic [7:0] C_PRINT_LO = 8'h20;
    localparam logic [7:0] C_DQUOTE   = 8'h22;
    localparam logic [7:0] C_SQUOTE   = 8'h27;
    localparam logic [7:0] C_BSLASH   = 8'h5C;
    localparam logic [7:0] C_DEL      = 8'h7F;
    localparam logic [7:0] C_LET_N    = 8'h6E;
    localparam logic [7:0] C_LET_R    = 8'h72;
    localparam logic [7:0] C_LET_T    = 8'h74;
    localparam logic [7:0] C_LET_X    = 8'h78;
    localparam logic [7:0] C_DIGIT_0  = 8'h30;
    localparam logic [7:0] C_ALPHA_A  = 8'h57;  // 'a' minus ten

    // Lower-case hex digit for one nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] ext;
        ext = {4'b0000, nib};
        if (nib < 4'd10) begin
            return C_DIGIT_0 + ext;
        end
        return C_ALPHA_A + ext;
    endfunction

    // Index of the final output byte for each kind.
    function automatic logic [1:0] last_idx(input t_kind kind);
        logic [1:0] idx;
        case (kind)
            K_PLAIN: idx = 2'd0;
            K_ESC:   idx = 2'd1;
            K_HEX:   idx = 2'd3;
            default: idx = 2'd0;
        endcase
        return idx;
    endfunction

endpackage

FILE: src/strenc_front.sv
module strenc_front (
    input  logic                  i_in_valid,
    input  logic [7:0]            i_in_byte,
    input  strenc_pkg::t_q_stat   i_q_stat,
    output logic                  o_in_ready,
    output logic                  o_push,
    output strenc_pkg::t_entry    o_entry
);
    import strenc_pkg::*;

    assign o_in_ready = !i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full;

    always_comb begin
        o_entry.kind = K_PLAIN;
        o_entry.ch   = i_in_byte;
        if (i_in_byte == C_NUL) begin
            o_entry.kind = K_PLAIN;
        end else if (i_in_byte == C_NL) begin
            o_entry.kind = K_ESC;
            o_entry.ch   = C_LET_N;
        end else if (i_in_byte == C_TAB) begin
            o_entry.kind = K_ESC;
            o_entry.ch   = C_LET_T;
        end else if (i_in_byte == C_CR) begin
            o_entry.kind = K_ESC;
            o_entry.ch   = C_LET_R;
        end else if (i_in_byte < C_PRINT_LO || i_in_byte >= C_DEL) begin
            o_entry.kind = K_HEX;
        end else if (i_in_byte == C_BSLASH || i_in_byte == C_DQUOTE
                     || i_in_byte == C_SQUOTE) begin
            o_entry.kind = K_ESC;
        end
    end

endmodule

FILE: src/strenc_queue.sv
module strenc_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  strenc_pkg::t_entry  i_entry,
    input  logic                i_pop,
    output strenc_pkg::t_entry  o_head,
    output strenc_pkg::t_q_stat o_stat
);
    import strenc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == FULL_CNT);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

FILE: src/strenc_back.sv
module strenc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  strenc_pkg::t_entry  i_head,
    input  strenc_pkg::t_q_stat i_q_stat,
    input  logic                i_out_ready,
    output logic                o_pop,
    output logic                o_out_valid,
    output logic [7:0]          o_out_byte,
    output logic                o_last_of_run
);
    import strenc_pkg::*;

    logic [1:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_last, n_last;
    logic       load;
    logic       at_last;
    logic [7:0] sel_byte;

    assign o_out_valid   = r_valid;
    assign o_out_byte    = r_byte;
    assign o_last_of_run = r_last;

    // The output register takes a byte of the head request when it is empty or being drained.
    assign load    = !i_q_stat.empty && (!r_valid || i_out_ready);
    assign at_last = (r_idx == last_idx(i_head.kind));
    assign o_pop   = load && at_last;

    always_comb begin
        sel_byte = i_head.ch;
        case (i_head.kind)
            K_PLAIN: sel_byte = i_head.ch;
            K_ESC:   sel_byte = (r_idx == 2'd0) ? C_BSLASH : i_head.ch;
            K_HEX: begin
                case (r_idx)
                    2'd0:    sel_byte = C_BSLASH;
                    2'd1:    sel_byte = C_LET_X;
                    2'd2:    sel_byte = hex_digit(i_head.ch[7:4]);
                    default: sel_byte = hex_digit(i_head.ch[3:0]);
                endcase
            end
            default: sel_byte = i_head.ch;
        endcase
    end

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        n_byte  = r_byte;
        n_last  = r_last;
        if (load) begin
            n_valid = 1'b1;
            n_byte  = sel_byte;
            n_last  = at_last;
            n_idx   = at_last ? 2'd0 : r_idx + 2'd1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
    end

endmodule

FILE: src/string_escape_encoder.sv
// Channel  Direction  Valid         Ready         Payload
// input    in         i_in_valid    o_in_ready    i_in_byte
// output   out        o_out_valid   i_out_ready   o_out_byte, o_last_of_run
//
// One output byte leaves per cycle while the output is ready and a request
// waits in the queue. A request gives one output byte for a plain byte or the
// end-of-string zero, two for a short escape and four for a hex escape.
// The input is taken in the same cycle it is offered while the queue of
// QUEUE_DEPTH classified requests has room, and data reaches the output
// through the queue and then the single output register of the back end.
// Reset is synchronous and active low and empties the queue and the output
// register. A stall on the output holds the output register and fills the
// queue; the input only stalls once the queue is full.
module string_escape_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);
    import strenc_pkg::*;

    t_entry  front_entry;
    t_entry  q_head;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    // The front end classifies each byte into its escape kind and the
    // character that follows the backslash, so the back end only counts
    // through the output bytes of one request.
    strenc_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_byte  (i_in_byte),
        .i_q_stat   (q_stat),
        .o_in_ready (o_in_ready),
        .o_push     (push),
        .o_entry    (front_entry)
    );

    // The queue decouples the two sides, so that a four-byte hex escape on
    // the back end does not stop the front end right away.
    strenc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    // The back end walks the bytes of the head request into its output
    // register and releases the request with its final byte.
    strenc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (q_head),
        .i_q_stat      (q_stat),
        .i_out_ready   (i_out_ready),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

`ifndef SYNTH
    // A zero byte only ever comes out as the end of a string, alone.
    a_zero_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_byte == C_NUL) |-> o_last_of_run)
        else $error("zero output byte without last_of_run");

    // The rest of an escape follows right after a taken non-final byte.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_of_run) |=> o_out_valid)
        else $error("escape sequence interrupted");

    // The queue cannot be full and empty at once.
    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty together");
`endif

endmodule

FILE: bench/string_escape_encoder_tb.sv
`timescale 1ns / 100ps

module string_escape_encoder_tb;
    import strenc_pkg::*;

    // Each side goes idle in about this many cycles of a hundred.
    localparam int IDLE_PCT = 27;
    // Random input bytes to send after the directed rows.
    localparam int RANDOM_BYTES = 326;
    // Cycles counted from reset release during which neither side idles.
    localparam int QUIET_FROM = 300;
    localparam int QUIET_TO = 700;
    // Cycles with no request moving on either channel before the run is
    // given up. A hex escape needs four output beats, and each one can wait
    // out a random stall, so a correct block never comes near this.
    localparam int STALL_LIMIT = 2000;
    // Extra cycles after the last expected byte, so that a stray output
    // still gets caught.
    localparam int DRAIN_CYCLES = 16;
    // A directed row whose typed length is zero takes its expectation from
    // the predictor instead.
    localparam logic [2:0] FROM_PREDICTOR = 3'd0;

    // Escaped form of one input byte: up to four bytes, left aligned, so
    // that the first byte on the output sits in bits 31:24.
    typedef struct packed {
        logic [2:0]  len;
        logic [31:0] text;
    } t_escape;

    // One row of stimulus, with an optional typed expectation.
    typedef struct packed {
        logic [7:0] ch;
        t_escape    typed;
    } t_row;

    // One output byte as it is expected on the output channel.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_out_beat;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_in_byte;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;

    t_row      rows[$];        // every request to send, directed rows first
    t_out_beat escaped_q[$];   // output bytes still owed by the block
    int        row_idx = 0;    // next row to offer on the input
    int        cycle = 0;      // cycles since reset release
    int        stall_cnt = 0;
    int        errors = 0;
    logic      drained = 1'b0; // all rows sent and every byte seen

    string_escape_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Lower-case ASCII hex digit for one nibble.
    function automatic logic [7:0] nibble_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return C_DIGIT_0 + {4'h0, nib};
        end
        return C_ALPHA_A + {4'h0, nib};
    endfunction

    // Predicts the escaped form of one raw string byte. The order of the
    // tests matters: the three named control characters win over the hex
    // form, and the quote and backslash test only sees printable bytes.
    function automatic t_escape escape_of(input logic [7:0] c);
        t_escape e;
        e.len = 3'd1;
        e.text = {c, 24'h0};
        if (c == C_NUL) begin
            // The end of the string is a lone zero byte.
            e.len = 3'd1;
            e.text = {C_NUL, 24'h0};
        end else if (c == C_NL) begin
            e.len = 3'd2;
            e.text = {C_BSLASH, C_LET_N, 16'h0};
        end else if (c == C_TAB) begin
            e.len = 3'd2;
            e.text = {C_BSLASH, C_LET_T, 16'h0};
        end else if (c == C_CR) begin
            e.len = 3'd2;
            e.text = {C_BSLASH, C_LET_R, 16'h0};
        end else if (c < C_PRINT_LO || c >= C_DEL) begin
            // Other control bytes, delete and every high byte.
            e.len = 3'd4;
            e.text = {C_BSLASH, C_LET_X, nibble_char(c[7:4]), nibble_char(c[3:0])};
        end else if (c == C_BSLASH || c == C_DQUOTE || c == C_SQUOTE) begin
            e.len = 3'd2;
            e.text = {C_BSLASH, c, 16'h0};
        end
        return e;
    endfunction

    function automatic t_row dir_row(input logic [7:0] ch, input logic [2:0] len,
                                     input logic [31:0] text);
        t_row r;
        r.ch = ch;
        r.typed.len = len;
        r.typed.text = text;
        return r;
    endfunction

    // A random string byte, weighted toward printable text but with every
    // class of escape well represented. The last class covers the whole
    // range, zero included, so any bit pattern can turn up.
    function automatic logic [7:0] string_byte();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: c = 8'($urandom_range(32'h20, 32'h7E));
            5: begin
                case ($urandom_range(0, 5))
                    0: c = C_NL;
                    1: c = C_TAB;
                    2: c = C_CR;
                    3: c = C_BSLASH;
                    4: c = C_DQUOTE;
                    default: c = C_SQUOTE;
                endcase
            end
            6: c = 8'($urandom_range(1, 31));
            7: c = 8'($urandom_range(128, 255));
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    // Stimulus, reset and the end of the run.
    initial begin
        int n_rand;
        int str_len;

        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_byte <= 8'h00;
        i_out_ready <= 1'b0;

        // Directed rows. The first request after reset, the range extremes
        // and the hex forms whose digits are easy to spell out carry their
        // expected bytes here; the rest go through the predictor.
        rows.push_back(dir_row(8'h41, 3'd1, {8'h41, 24'h0}));
        rows.push_back(dir_row(C_NUL, 3'd1, {C_NUL, 24'h0}));
        rows.push_back(dir_row(8'hFF, 3'd4, {C_BSLASH, C_LET_X, 8'h66, 8'h66}));
        rows.push_back(dir_row(8'h80, 3'd4, {C_BSLASH, C_LET_X, 8'h38, 8'h30}));
        rows.push_back(dir_row(C_DEL, 3'd4, {C_BSLASH, C_LET_X, 8'h37, 8'h66}));
        rows.push_back(dir_row(8'h01, 3'd4, {C_BSLASH, C_LET_X, 8'h30, 8'h31}));
        rows.push_back(dir_row(8'h1F, FROM_PREDICTOR, 32'h0));
        rows.push_back(dir_row(C_PRINT_LO, 3'd1, {C_PRINT_LO, 24'h0}));
        rows.push_back(dir_row(8'h7E, 3'd1, {8'h7E, 24'h0}));
        rows.push_back(dir_row(C_NL, FROM_PREDICTOR, 32'h0));
        rows.push_back(dir_row(C_TAB, FROM_PREDICTOR, 32'h0));
        rows.push_back(dir_row(C_CR, FROM_PREDICTOR, 32'h0));
        rows.push_back(dir_row(C_BSLASH, FROM_PREDICTOR, 32'h0));
        rows.push_back(dir_row(C_DQUOTE, FROM_PREDICTOR, 32'h0));
        rows.push_back(dir_row(C_SQUOTE, FROM_PREDICTOR, 32'h0));
        // Neighbors of the named control characters take the hex form.
        rows.push_back(dir_row(8'h08, FROM_PREDICTOR, 32'h0));
        rows.push_back(dir_row(8'h0B, FROM_PREDICTOR, 32'h0));
        rows.push_back(dir_row(8'h0C, FROM_PREDICTOR, 32'h0));
        rows.push_back(dir_row(8'h0E, FROM_PREDICTOR, 32'h0));
        rows.push_back(dir_row(8'hAA, FROM_PREDICTOR, 32'h0));
        rows.push_back(dir_row(8'h55, FROM_PREDICTOR, 32'h0));
        rows.push_back(dir_row(8'h5B, FROM_PREDICTOR, 32'h0));
        rows.push_back(dir_row(8'h5D, FROM_PREDICTOR, 32'h0));
        rows.push_back(dir_row(C_NUL, FROM_PREDICTOR, 32'h0));

        // Random part: mostly whole strings closed by a zero byte, with an
        // occasional loose byte of any value thrown in between.
        n_rand = 0;
        while (n_rand < RANDOM_BYTES) begin
            if ($urandom_range(0, 9) == 0) begin
                rows.push_back(dir_row(8'($urandom_range(0, 255)), FROM_PREDICTOR, 32'h0));
                n_rand++;
            end else begin
                str_len = $urandom_range(1, 12);
                for (int k = 0; k < str_len; k++) begin
                    rows.push_back(dir_row(string_byte(), FROM_PREDICTOR, 32'h0));
                end
                rows.push_back(dir_row(C_NUL, FROM_PREDICTOR, 32'h0));
                n_rand += str_len + 1;
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk); while (!drained);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (escaped_q.size() != 0) begin
            $error("%0d expected output bytes never arrived", escaped_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("string_escape_encoder test passed");
        end else begin
            $display("string_escape_encoder test failed");
        end
        $finish;
    end

    // Driver and checker in one process. Inputs and outputs are sampled at
    // the rising edge before any of the nonblocking updates land, so the
    // values seen are the ones the block saw at that same edge.
    always @(posedge i_clk) begin
        t_escape   e;
        t_out_beat want;
        logic      took_in;
        logic      took_out;
        logic      quiet;

        if (i_rst_n) begin
            took_in = i_in_valid && o_in_ready;
            took_out = o_out_valid && i_out_ready;
            quiet = (cycle >= QUIET_FROM) && (cycle < QUIET_TO);
            cycle <= cycle + 1;

            // An accepted request owes one to four output bytes, the last
            // one flagged.
            if (took_in) begin
                if (rows[row_idx].typed.len == FROM_PREDICTOR) begin
                    e = escape_of(rows[row_idx].ch);
                end else begin
                    e = rows[row_idx].typed;
                end
                for (int k = 0; k < int'(e.len); k++) begin
                    want.ch = e.text[31 - 8 * k -: 8];
                    want.last = (k == int'(e.len) - 1);
                    escaped_q.push_back(want);
                end
                row_idx++;
            end

            // Every output byte is matched against the oldest one owed.
            if (took_out) begin
                if (escaped_q.size() == 0) begin
                    $error("output byte 0x%02h arrived with nothing expected", o_out_byte);
                    errors++;
                end else begin
                    want = escaped_q.pop_front();
                    if (o_out_byte !== want.ch) begin
                        $error("out_byte: expected 0x%02h, got 0x%02h", want.ch, o_out_byte);
                        errors++;
                    end
                    if (o_last_of_run !== want.last) begin
                        $error("last_of_run: expected %0b, got %0b", want.last, o_last_of_run);
                        errors++;
                    end
                end
            end

            // A pending request keeps valid and its byte until it is taken.
            // Otherwise the next row goes out unless this cycle idles.
            if (!i_in_valid || took_in) begin
                if (row_idx < rows.size() &&
                    (quiet || int'($urandom_range(0, 99)) >= IDLE_PCT)) begin
                    i_in_valid <= 1'b1;
                    i_in_byte <= rows[row_idx].ch;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end

            i_out_ready <= quiet || int'($urandom_range(0, 99)) >= IDLE_PCT;
            drained <= (row_idx == rows.size()) && (escaped_q.size() == 0);
        end
    end

    // Watchdog: gives up when neither channel has moved a request for too
    // long. Output bytes that nobody is waiting for do not count as
    // progress, so a block that keeps talking cannot hold the run open.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) ||
                (o_out_valid && i_out_ready && escaped_q.size() != 0)) begin
                stall_cnt <= 0;
            end else if (stall_cnt >= STALL_LIMIT) begin
                $display("string_escape_encoder test failed");
                $finish;
            end else begin
                stall_cnt <= stall_cnt + 1;
            end
        end
    end

endmodule
